// ===== hw/rtl/bas_pkg.sv =====
// Package for the bounded word array: sizes, field types, command codes
// and the RAM request bundle. Depends on nothing; the interfaces, the top level and the sequencer import it.
`timescale 1ns / 1ps

package bas_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;

    typedef logic [KIND_W-1:0]         kind_t;
    typedef logic signed [VALUE_W-1:0] word_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [CAP_W-1:0]          cap_t;
    typedef logic [IDX_W-1:0]          idx_t;

    localparam kind_t KIND_APPEND  = 2'd0;
    localparam kind_t KIND_GET     = 2'd1;
    localparam kind_t KIND_SORT    = 2'd2;
    localparam kind_t KIND_REVERSE = 2'd3;

    localparam cap_t   CAP_RESET  = CAP_W'(16);
    localparam count_t COUNT_MAX  = COUNT_W'(DEPTH);
    localparam word_t  WORD_FAIL  = '1;

    typedef struct packed {
        logic  we;
        idx_t  waddr;
        word_t wdata;
        logic  re;
        idx_t  raddr;
    } ram_req_t;

endpackage

// ===== hw/rtl/bas_if.sv =====
// Valid/ready channel interfaces for the command and response streams.
// Depends on bas_pkg for the payload types.
`timescale 1ns / 1ps

interface bas_cmd_if;
    import bas_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    word_t value;
    pos_t  position;

    modport source (output valid, output kind, output value, output position, input ready);
    modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface bas_rsp_if;
    import bas_pkg::*;

    logic   valid;
    logic   ready;
    logic   ok;
    word_t  read_value;
    count_t item_count;
    logic   is_empty;
    logic   is_full;

    modport source (output valid, output ok, output read_value, output item_count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input read_value, input item_count,
                    input is_empty, input is_full, output ready);
endinterface

// ===== hw/rtl/bounded_array_sort_reverse.sv =====
// Bounded array of signed words: append, get, exchange sort and reverse.
// One command at a time: the next transfer is taken once the sequencer is idle again;
// the sort time is set by one RAM read port feeding one shared compare unit.
// Reset clears the fill count and sets capacity to 16; store contents stay as they are.
`timescale 1ns / 1ps

module bounded_array_sort_reverse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  bas_pkg::cap_t cfg_wdata,
    bas_cmd_if.sink       cmd,
    bas_rsp_if.source     rsp
);
    import bas_pkg::*;

    cap_t     capacity_reg;
    count_t   eff_cap;
    ram_req_t ram_req;
    word_t    ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    // saturate capacity at the store depth
    assign eff_cap = (COUNT_W'(capacity_reg) > COUNT_MAX) ? COUNT_MAX : COUNT_W'(capacity_reg);

    bas_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    bas_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_cap   (eff_cap),
        .cmd       (cmd),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

// ===== hw/rtl/bas_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; width and depth come in as parameters.
`timescale 1ns / 1ps

module bas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/bas_seq.sv =====
// Command sequencer: fill count, append/get handling, exchange-sort walks over
// the RAM through one compare unit, reverse walks, and the response register.
// Depends on bas_pkg and the channel interfaces in bas_if.
`timescale 1ns / 1ps

module bas_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  bas_pkg::count_t   eff_cap,
    bas_cmd_if.sink           cmd,
    bas_rsp_if.source         rsp,
    output bas_pkg::ram_req_t ram_req,
    input  bas_pkg::word_t    ram_rdata
);
    import bas_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_GET_WAIT = 4'd1;
    localparam logic [ST_W-1:0] ST_S_LOADI  = 4'd2;
    localparam logic [ST_W-1:0] ST_S_CMP    = 4'd3;
    localparam logic [ST_W-1:0] ST_S_WBI    = 4'd4;
    localparam logic [ST_W-1:0] ST_R_HI     = 4'd5;
    localparam logic [ST_W-1:0] ST_R_WLO    = 4'd6;
    localparam logic [ST_W-1:0] ST_R_WHI    = 4'd7;
    localparam logic [ST_W-1:0] ST_FIN      = 4'd8;

    logic [ST_W-1:0] state_reg, state_next;
    count_t          count_reg, count_next;
    logic            rsp_valid_reg, rsp_valid_next;

    idx_t   i_reg, i_next;
    idx_t   j_reg, j_next;
    word_t  hold_reg, hold_next;
    logic   res_ok_reg, res_ok_next;
    word_t  res_val_reg, res_val_next;
    logic   out_ok_reg, out_ok_next;
    word_t  out_val_reg, out_val_next;
    count_t out_count_reg, out_count_next;
    logic   out_empty_reg, out_empty_next;
    logic   out_full_reg, out_full_next;

    logic   accept;
    pos_t   pos_m1;
    count_t cnt_m1;
    idx_t   i_inc;
    idx_t   j_inc;
    idx_t   j_dec;
    logic   hold_greater;

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign accept         = cmd.valid && cmd.ready;
    assign pos_m1         = cmd.position - POS_W'(1);
    assign cnt_m1         = count_reg - COUNT_W'(1);
    assign i_inc          = i_reg + IDX_W'(1);
    assign j_inc          = j_reg + IDX_W'(1);
    assign j_dec          = j_reg - IDX_W'(1);
    // the one compare unit shared by every sort compare step
    assign hold_greater   = hold_reg > ram_rdata;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = out_ok_reg;
    assign rsp.read_value = out_val_reg;
    assign rsp.item_count = out_count_reg;
    assign rsp.is_empty   = out_empty_reg;
    assign rsp.is_full    = out_full_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        hold_next      = hold_reg;
        res_ok_next    = res_ok_reg;
        res_val_next   = res_val_reg;
        out_ok_next    = out_ok_reg;
        out_val_next   = out_val_reg;
        out_count_next = out_count_reg;
        out_empty_next = out_empty_reg;
        out_full_next  = out_full_reg;
        ram_req        = '0;

        // drop the held response once it transfers
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_ok_next  = 1'b1;
                    res_val_next = '0;
                    state_next   = ST_FIN;
                    unique case (cmd.kind)
                        KIND_APPEND:
                        begin
                            if (count_reg < eff_cap)
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = count_reg[IDX_W-1:0];
                                ram_req.wdata = cmd.value;
                                count_next    = count_reg + COUNT_W'(1);
                            end
                            else
                            begin
                                res_ok_next = 1'b0;
                            end
                        end
                        KIND_GET:
                        begin
                            if (cmd.position == '0 || COUNT_W'(cmd.position) > count_reg)
                            begin
                                res_ok_next  = 1'b0;
                                res_val_next = WORD_FAIL;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = pos_m1[IDX_W-1:0];
                                state_next    = ST_GET_WAIT;
                            end
                        end
                        KIND_SORT:
                        begin
                            if (count_reg >= COUNT_W'(2))
                            begin
                                i_next        = '0;
                                j_next        = IDX_W'(1);
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                state_next    = ST_S_LOADI;
                            end
                        end
                        KIND_REVERSE:
                        begin
                            if (count_reg >= COUNT_W'(2))
                            begin
                                i_next        = '0;
                                j_next        = cnt_m1[IDX_W-1:0];
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                state_next    = ST_R_HI;
                            end
                        end
                    endcase
                end
            end
            ST_GET_WAIT:
            begin
                res_val_next = ram_rdata;
                state_next   = ST_FIN;
            end
            ST_S_LOADI:
            begin
                hold_next     = ram_rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = j_reg;
                state_next    = ST_S_CMP;
            end
            ST_S_CMP:
            begin
                // hold keeps the running minimum for position i; swap in any smaller word read
                if (hold_greater)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = j_reg;
                    ram_req.wdata = hold_reg;
                    hold_next     = ram_rdata;
                end
                if (COUNT_W'(j_reg) + COUNT_W'(1) < count_reg)
                begin
                    j_next        = j_inc;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = j_inc;
                end
                else
                begin
                    state_next = ST_S_WBI;
                end
            end
            ST_S_WBI:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = i_reg;
                ram_req.wdata = hold_reg;
                if (COUNT_W'(i_inc) + COUNT_W'(1) < count_reg)
                begin
                    i_next        = i_inc;
                    j_next        = i_inc + IDX_W'(1);
                    ram_req.re    = 1'b1;
                    ram_req.raddr = i_inc;
                    state_next    = ST_S_LOADI;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_R_HI:
            begin
                hold_next     = ram_rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = j_reg;
                state_next    = ST_R_WLO;
            end
            ST_R_WLO:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = i_reg;
                ram_req.wdata = ram_rdata;
                state_next    = ST_R_WHI;
            end
            ST_R_WHI:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = hold_reg;
                i_next        = i_inc;
                j_next        = j_dec;
                if (i_inc < j_dec)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = i_inc;
                    state_next    = ST_R_HI;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // wait here until the response register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_val_next   = res_val_reg;
                    out_count_next = count_reg;
                    out_empty_next = (count_reg == '0);
                    out_full_next  = (count_reg >= eff_cap);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        hold_reg      <= hold_next;
        res_ok_reg    <= res_ok_next;
        res_val_reg   <= res_val_next;
        out_ok_reg    <= out_ok_next;
        out_val_reg   <= out_val_next;
        out_count_reg <= out_count_next;
        out_empty_reg <= out_empty_next;
        out_full_reg  <= out_full_next;
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("fill count beyond store depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("RAM read and write at the same address");

    a_full_append_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.kind == KIND_APPEND && count_reg >= eff_cap) |=> $stable(count_reg))
        else $error("append taken while full");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("response raised outside the finish step");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S_CMP) |-> (COUNT_W'(j_reg) < count_reg && i_reg < j_reg))
        else $error("sort compare outside the held words");

endmodule
